// ===== sv/tsm_pkg.sv =====
// Shared types and constants for the timer slot multiplexer.
// Holds the scan token that travels along the slot cells and the status codes.
// No dependencies.
`default_nettype none

package tsm_pkg;

  // Number of timer slots, one cell each. Valid range is 1 to 31.
  localparam int SLOTS = 16;

  // Slot index width. It also holds SLOTS itself, which means "no slot".
  localparam int IDX_W = $clog2(SLOTS + 1);

  localparam int DL_W   = 32;
  localparam int HD_W   = 16;
  localparam int FREQ_W = 32;
  localparam int CNT_W  = 64;
  localparam int ST_W   = 2;

  localparam logic [IDX_W-1:0] NO_SLOT = IDX_W'(SLOTS);

  localparam logic [DL_W-1:0]   IDLE_RESET = DL_W'(60000);
  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(19200000);

  // Item kinds.
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_EXPIRE = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_IDLE = 1'b0;
  localparam logic CFG_FREQ = 1'b1;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_ADDED   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_FIRED   = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTHING = 2'd3;

  // Scan token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [DL_W-1:0]   deadline;
    logic [HD_W-1:0]   handle;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  next_slot;
    logic              claimed;
    logic              fired;
    logic [HD_W-1:0]   fired_handle;
    logic              found;
    logic [DL_W-1:0]   best;
    logic [IDX_W-1:0]  best_idx;
  } tok_t;

endpackage

`default_nettype wire

// ===== sv/timer_slot_multiplexer.sv =====
// Top level of the timer slot multiplexer: entry register, row of slot cells,
// compare-count multiplier and output register. Depends on tsm_pkg, tsm_cell.
//
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  tuser: kind; tdata: deadline_sec, handle
// m_*       out  m_tvalid/m_tready  tdata: status, fired_handle, pending,
//                                   next_deadline_sec, compare_count
// cfg_*     in   cfg_we             cfg_addr: register index; cfg_wdata: value
//
// An item passes from acceptance to a valid result through the entry register,
// which loads at the accepting edge, then the slot cells in turn as the scan
// token walks the row, then the 32x32 compare-count multiply stage and the
// output register.
// One item is in the cell row at a time; the next item is taken once the
// previous result has reached the output register, even if it is not yet taken.
// A stalled output holds its item; a finished result waiting behind it stays
// in the multiply stage. Synchronous reset frees all slots and restores both
// configuration registers to their defaults.
`default_nettype none

module timer_slot_multiplexer (
  input  logic         clk,
  input  logic         rst,
  // Input items.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // [31:0] deadline_sec, [47:32] handle
  input  logic         s_tuser,   // kind: 0 add, 1 expiry
  // Result items.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // [1:0] status, [17:2] fired_handle,
                                  // [18] pending, [50:19] next_deadline_sec,
                                  // [114:51] compare_count, rest zero
  // Configuration writes.
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  // Configuration registers.
  logic [tsm_pkg::DL_W-1:0]   idle_deadline;
  logic [tsm_pkg::FREQ_W-1:0] counter_freq;

  // Slot chosen by the last search; NO_SLOT when nothing is pending.
  logic [tsm_pkg::IDX_W-1:0] next_slot;

  // Busy from acceptance until the result moves into the output register.
  logic busy;

  // Token taps: tok[0] is the entry register, tok[k+1] leaves cell k.
  tsm_pkg::tok_t tok [tsm_pkg::SLOTS+1];
  logic [tsm_pkg::SLOTS:0] tok_valid;

  // Multiply stage.
  logic                       prod_valid;
  logic [tsm_pkg::ST_W-1:0]   prod_status;
  logic [tsm_pkg::HD_W-1:0]   prod_handle;
  logic                       prod_pending;
  logic [tsm_pkg::DL_W-1:0]   prod_deadline;
  logic [tsm_pkg::CNT_W-1:0]  prod_count;

  // Output register fields.
  logic [tsm_pkg::ST_W-1:0]   out_status;
  logic [tsm_pkg::HD_W-1:0]   out_handle;
  logic                       out_pending;
  logic [tsm_pkg::DL_W-1:0]   out_deadline;
  logic [tsm_pkg::CNT_W-1:0]  out_count;

  logic          s_fire;
  logic          prod_move;
  tsm_pkg::tok_t tok_last;
  logic [tsm_pkg::ST_W-1:0] last_status;

  assign s_tready  = !busy;
  assign s_fire    = s_tvalid && s_tready;
  assign prod_move = prod_valid && (!m_tvalid || m_tready);
  assign tok_last  = tok[tsm_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_deadline <= tsm_pkg::IDLE_RESET;
      counter_freq  <= tsm_pkg::FREQ_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        tsm_pkg::CFG_IDLE: idle_deadline <= cfg_wdata;
        tsm_pkg::CFG_FREQ: counter_freq  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (s_fire) begin
      busy <= 1'b1;
    end else if (prod_move) begin
      busy <= 1'b0;
    end
  end

  // Entry: the search starts from the idle bound, so an empty search reports it.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid        <= s_fire;
      tok[0].kind         <= s_tuser;
      tok[0].deadline     <= s_tdata[31:0];
      tok[0].handle       <= s_tdata[47:32];
      tok[0].idx          <= '0;
      tok[0].next_slot    <= next_slot;
      tok[0].claimed      <= 1'b0;
      tok[0].fired        <= 1'b0;
      tok[0].fired_handle <= '0;
      tok[0].found        <= 1'b0;
      tok[0].best         <= idle_deadline;
      tok[0].best_idx     <= tsm_pkg::NO_SLOT;
    end
  end

  for (genvar k = 0; k < tsm_pkg::SLOTS; k++) begin : g_cell
    tsm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1])
    );
  end

  for (genvar k = 0; k <= tsm_pkg::SLOTS; k++) begin : g_valid
    assign tok_valid[k] = tok[k].valid;
  end

  // The search result of the token leaving the last cell picks the next slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot <= tsm_pkg::NO_SLOT;
    end else if (tok_last.valid) begin
      next_slot <= tok_last.found ? tok_last.best_idx : tsm_pkg::NO_SLOT;
    end
  end

  always_comb begin
    if (tok_last.kind == tsm_pkg::KIND_ADD) begin
      last_status = tok_last.claimed ? tsm_pkg::ST_ADDED : tsm_pkg::ST_FULL;
    end else begin
      last_status = tok_last.fired ? tsm_pkg::ST_FIRED : tsm_pkg::ST_NOTHING;
    end
  end

  // Multiply stage. It holds while the output register is still occupied.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (tok_last.valid) begin
      prod_valid <= 1'b1;
    end else if (prod_move) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_last.valid) begin
      prod_status   <= last_status;
      prod_handle   <= tok_last.fired ? tok_last.fired_handle : '0;
      prod_pending  <= tok_last.found;
      prod_deadline <= tok_last.best;
      prod_count    <= tsm_pkg::CNT_W'(tok_last.best) * tsm_pkg::CNT_W'(counter_freq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (prod_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_move) begin
      out_status   <= prod_status;
      out_handle   <= prod_handle;
      out_pending  <= prod_pending;
      out_deadline <= prod_deadline;
      out_count    <= prod_count;
    end
  end

  assign m_tdata = {5'b0, out_count, out_deadline, out_pending, out_handle, out_status};

  // Only one token may be in the cell row at any time.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid))
    else $error("more than one scan token in the slot row");

  // A result never reaches the multiply stage while it still holds one.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    tok_last.valid |-> !prod_valid)
    else $error("result reached the multiply stage while it was full");

  // A handle is only reported for a fired timer.
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_status != tsm_pkg::ST_FIRED)) |-> (out_handle == '0))
    else $error("handle reported without a fired timer");

  // A pending result lies strictly below the idle bound.
  a_pending_below: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_pending) |-> (out_deadline < idle_deadline))
    else $error("pending deadline not below idle bound");

  // The stored next slot is a real slot or the none marker.
  a_next_range: assert property (@(posedge clk) disable iff (rst)
    next_slot <= tsm_pkg::NO_SLOT)
    else $error("next slot out of range");

endmodule

`default_nettype wire

// ===== sv/tsm_cell.sv =====
// One timer slot cell: holds a slot and advances the scan token by one slot.
// Depends on tsm_pkg for the token type.
`default_nettype none

module tsm_cell (
  input  logic          clk,
  input  logic          rst,
  input  tsm_pkg::tok_t tok_in,
  output tsm_pkg::tok_t tok_out
);

  logic                     used;
  logic [tsm_pkg::DL_W-1:0] deadline;
  logic [tsm_pkg::HD_W-1:0] handle;

  logic                     hit_add;
  logic                     hit_exp;
  logic                     used_next;
  logic [tsm_pkg::DL_W-1:0] deadline_next;
  tsm_pkg::tok_t            tok_next;

  // The slot operation happens first, then this slot joins the minimum search
  // with its updated contents. Earlier slots are never touched by the item.
  always_comb begin
    hit_add = tok_in.valid && (tok_in.kind == tsm_pkg::KIND_ADD) &&
              !tok_in.claimed && !used;
    hit_exp = tok_in.valid && (tok_in.kind == tsm_pkg::KIND_EXPIRE) &&
              (tok_in.idx == tok_in.next_slot) && used;

    used_next     = hit_add ? 1'b1 : (hit_exp ? 1'b0 : used);
    deadline_next = hit_add ? tok_in.deadline : deadline;

    tok_next     = tok_in;
    tok_next.idx = tok_in.idx + tsm_pkg::IDX_W'(1);
    if (hit_add) begin
      tok_next.claimed = 1'b1;
    end
    if (hit_exp) begin
      tok_next.fired        = 1'b1;
      tok_next.fired_handle = handle;
    end
    if (used_next && (deadline_next < tok_in.best)) begin
      tok_next.best     = deadline_next;
      tok_next.best_idx = tok_in.idx;
      tok_next.found    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else begin
      used <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_add) begin
      deadline <= tok_in.deadline;
      handle   <= tok_in.handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_timer_slot_multiplexer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for timer_slot_multiplexer: drives timer add and expiry
// items with random gaps and stalls, mirrors the slot table and checks each result.
// Depends on tsm_pkg and timer_slot_multiplexer.

module tb_timer_slot_multiplexer;
  import tsm_pkg::*;

  // Cycles without any handshake before the run is declared hung. One item
  // needs at most a sender gap, its pass through the block and a receiver
  // stall, so this leaves a wide margin.
  localparam int HANG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 106;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [47:0]  s_tdata;   // [31:0] deadline_sec, [47:32] handle
  logic         s_tuser;   // kind
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;   // [1:0] status, [17:2] fired_handle, [18] pending,
                           // [50:19] next_deadline_sec, [114:51] compare_count
  logic         cfg_we;
  logic         cfg_addr;
  logic [31:0]  cfg_wdata;

  // When set, the sender or the receiver runs without any idle cycles.
  bit src_eager;
  bit sink_eager;
  bit timed_out;

  timer_slot_multiplexer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [HD_W-1:0]  fired_handle;
    logic             pending;
    logic [DL_W-1:0]  next_dl;
    logic [CNT_W-1:0] compare_count;
  } timer_result_t;

  // Shadow copy of the slot table and the two registers. Each accepted item is
  // applied here and the result it must produce is queued until the block
  // delivers one.
  class slot_table_mirror;
    logic [DL_W-1:0]   idle_dl;
    logic [FREQ_W-1:0] freq;
    bit                used [SLOTS];
    logic [DL_W-1:0]   slot_dl [SLOTS];
    logic [HD_W-1:0]   slot_hd [SLOTS];
    int                next_idx;
    timer_result_t     owed_results [$];
    int                errors;
    int                items;
    int                fired_cnt;
    int                full_cnt;
    int                nothing_cnt;

    function new();
      idle_dl = IDLE_RESET;
      freq    = FREQ_RESET;
      foreach (used[i]) begin
        used[i]    = 1'b0;
        slot_dl[i] = '0;
        slot_hd[i] = '0;
      end
      next_idx    = SLOTS;
      errors      = 0;
      items       = 0;
      fired_cnt   = 0;
      full_cnt    = 0;
      nothing_cnt = 0;
    endfunction

    function void write_reg(logic addr, logic [31:0] value);
      if (addr == CFG_IDLE) begin
        idle_dl = value;
      end else begin
        freq = value;
      end
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (used[i]) n += used[i];
      return n;
    endfunction

    function void apply_item(logic kind, logic [DL_W-1:0] dl, logic [HD_W-1:0] hd);
      timer_result_t r;
      int            free_idx;
      logic [63:0]   wide_dl;
      r = '0;
      free_idx = SLOTS;
      items++;
      if (kind == KIND_ADD) begin
        // The lowest free slot takes the timer.
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!used[i]) free_idx = i;
        end
        if (free_idx < SLOTS) begin
          used[free_idx]    = 1'b1;
          slot_dl[free_idx] = dl;
          slot_hd[free_idx] = hd;
          r.status = ST_ADDED;
        end else begin
          r.status = ST_FULL;
          full_cnt++;
        end
      end else begin
        // An expiry frees the slot chosen by the previous search, if any.
        if (next_idx < SLOTS && used[next_idx]) begin
          used[next_idx] = 1'b0;
          r.fired_handle = slot_hd[next_idx];
          r.status = ST_FIRED;
          fired_cnt++;
        end else begin
          r.status = ST_NOTHING;
          nothing_cnt++;
        end
      end
      // Search for the earliest deadline strictly below the idle bound; the
      // strict compare keeps the lowest slot on ties.
      r.next_dl = idle_dl;
      next_idx = SLOTS;
      for (int i = 0; i < SLOTS; i++) begin
        if (used[i] && slot_dl[i] < r.next_dl) begin
          r.next_dl = slot_dl[i];
          next_idx = i;
          r.pending = 1'b1;
        end
      end
      wide_dl = r.next_dl;
      r.compare_count = wide_dl * freq;
      owed_results.push_back(r);
    endfunction

    function void field_check(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void compare_result(logic [119:0] data);
      timer_result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with no item outstanding, expected none, got %h",
                 $time, data);
        return;
      end
      want = owed_results.pop_front();
      field_check("status", want.status, data[1:0]);
      field_check("fired_handle", want.fired_handle, data[17:2]);
      field_check("pending", want.pending, data[18]);
      field_check("next_deadline_sec", want.next_dl, data[50:19]);
      field_check("compare_count", want.compare_count, data[114:51]);
      field_check("tdata padding", 64'd0, data[119:115]);
    endfunction
  endclass

  slot_table_mirror mirror = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every input has a defined value from time zero.
  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    m_tready   = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_IDLE;
    cfg_wdata  = '0;
    src_eager  = 1'b0;
    sink_eager = 1'b0;
    timed_out  = 1'b0;
  end

  // Presents one item after a random gap and holds it until it is taken.
  // Valid stays high after acceptance so back-to-back items need no toggle.
  task automatic send_item(logic kind, logic [DL_W-1:0] dl, logic [HD_W-1:0] hd);
    int gap;
    gap = src_eager ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {hd, dl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mirror.apply_item(kind, dl, hd);
  endtask

  // Drops valid and waits until every outstanding result has been delivered.
  // Each item yields exactly one result, so an empty queue means the block is idle.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (mirror.owed_results.size() != 0) @(posedge clk);
  endtask

  // Writes both registers on consecutive cycles while the block is idle.
  task automatic write_config(logic [DL_W-1:0] idle_dl, logic [FREQ_W-1:0] freq);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_IDLE;
    cfg_wdata <= idle_dl;
    @(negedge clk);
    cfg_addr  <= CFG_FREQ;
    cfg_wdata <= freq;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mirror.write_reg(CFG_IDLE, idle_dl);
    mirror.write_reg(CFG_FREQ, freq);
  endtask

  // Deadlines are drawn mostly from a narrow low range, so that ties happen, and
  // around the current idle bound, so that the strict compare is exercised.
  function automatic logic [DL_W-1:0] pick_deadline();
    logic [DL_W-1:0] dl;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: dl = $urandom_range(0, 63);
      4:          dl = mirror.idle_dl - $urandom_range(1, 4);
      5:          dl = mirror.idle_dl + $urandom_range(0, 3);
      9:          dl = $urandom_range(0, 1) ? '1 : '0;
      default:    dl = $urandom;
    endcase
    return dl;
  endfunction

  // Random traffic in bursts: runs of adds that fill the table, runs of expiries
  // that drain it, and mixed runs. Some bursts run without gaps on either side.
  task automatic run_random(int count);
    int   left;
    int   len;
    int   mode;
    logic kind;
    left = count;
    while (left > 0) begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 20);
      if (len > left) len = left;
      src_eager  = ($urandom_range(0, 3) == 0);
      sink_eager = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < len; n++) begin
        case (mode)
          0:       kind = KIND_ADD;
          1:       kind = KIND_EXPIRE;
          default: kind = $urandom_range(0, 1) ? KIND_EXPIRE : KIND_ADD;
        endcase
        send_item(kind, pick_deadline(), $urandom_range(0, 65535));
      end
      left -= len;
    end
    src_eager  = 1'b0;
    sink_eager = 1'b0;
  endtask

  // Result side: stalls a random number of cycles per item, then takes it.
  initial begin : result_sink
    int stall;
    @(negedge rst);
    forever begin
      stall = sink_eager ? 0 : $urandom_range(0, 8);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      mirror.compare_result(m_tdata);
    end
  end

  // Hang detector: counts consecutive cycles in which neither side moves an item and no register is written.
  initial begin : hang_watch
    int quiet;
    quiet = 0;
    @(negedge rst);
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    timed_out = 1'b1;
    $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
    $display("tb_timer_slot_multiplexer: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [DL_W-1:0]   idle_set [PHASES];
    logic [FREQ_W-1:0] freq_set [PHASES];
    // Register settings per phase: defaults, both extremes of each register,
    // a zero frequency, a tiny bound that catches the low tie range, then random.
    idle_set[0] = IDLE_RESET;  freq_set[0] = FREQ_RESET;
    idle_set[1] = '0;          freq_set[1] = 32'd1;
    idle_set[2] = '1;          freq_set[2] = '1;
    idle_set[3] = 32'd1000;    freq_set[3] = '0;
    idle_set[4] = 32'd40;      freq_set[4] = 32'd3;
    for (int p = 5; p < PHASES; p++) begin
      idle_set[p] = $urandom_range(0, 1) ? $urandom_range(0, 100) : $urandom;
      freq_set[p] = $urandom;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, with the reset register values.
    send_item(KIND_EXPIRE, 32'd0, 16'd0);            // expiry on an empty table
    send_item(KIND_ADD, 32'd0, 16'h0000);            // smallest deadline and handle
    send_item(KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF);    // largest, never selected
    send_item(KIND_ADD, IDLE_RESET - 1, 16'h1234);   // just below the bound
    send_item(KIND_ADD, IDLE_RESET, 16'h4321);       // at the bound, never selected
    send_item(KIND_ADD, 32'd5, 16'hA5A5);            // two equal deadlines:
    send_item(KIND_ADD, 32'd5, 16'h5A5A);            // the lower slot must win
    repeat (4) send_item(KIND_EXPIRE, 32'd0, 16'd0); // fires 0, both ties, bound-1
    // Only slots at or above the bound remain, so this expiry finds nothing.
    send_item(KIND_EXPIRE, 32'd0, 16'd0);
    // Fill the table and push one more add into it.
    for (int i = 0; i < SLOTS - 1; i++) begin
      send_item(KIND_ADD, 32'd100 - i, 16'hC000 + i);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_config(idle_set[p], freq_set[p]);
      run_random(PHASE_ITEMS);
      drain();
    end

    // Any result arriving now would have no item behind it.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items over %0d register settings: %0d fired, %0d dropped on",
             mirror.items, PHASES + 1, mirror.fired_cnt, mirror.full_cnt);
    $display("a full table, %0d expiries with nothing pending.", mirror.nothing_cnt);
    if (mirror.errors == 0 && !timed_out && mirror.owed_results.size() == 0) begin
      $display("tb_timer_slot_multiplexer: done, clean");
    end else begin
      $display("tb_timer_slot_multiplexer: done, errors");
    end
    $finish;
  end

endmodule
